// File: hdl/shl_pkg.sv
// Package for the shift insert list: sizes, request and status codes,
// and the command word that the top level broadcasts to the slot cells.
// No dependencies.
package shl_pkg;

  // Built storage
  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 64;

  // Fixed port field widths
  localparam int REQ_W    = 3;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int CAP_W    = 5;

  // Derived widths
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_POS   = 3'd1,
    REQ_ADD_END   = 3'd2,
    REQ_REM_POS   = 3'd3,
    REQ_REM_END   = 3'd4,
    REQ_READ_POS  = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [CNT_W-1:0]       pos;
    logic [CNT_W-1:0]       held;
    logic [ENTRY_WIDTH-1:0] word;
  } cell_cmd_t;

endpackage

// File: hdl/shl_in_if.sv
// Request channel of the shift insert list.
// Depends on shl_pkg for field widths.
interface shl_in_if import shl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] entry_in;

  modport source (output valid, req_type, position, entry_in, input ready);
  modport sink   (input valid, req_type, position, entry_in, output ready);
endinterface

// File: hdl/shl_out_if.sv
// Result channel of the shift insert list.
// Depends on shl_pkg for field widths.
interface shl_out_if import shl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_count;
  logic [DATA_W-1:0]   entry_out;

  modport source (output valid, status, fill_count, entry_out, input ready);
  modport sink   (input valid, status, fill_count, entry_out, output ready);
endinterface

// File: hdl/shl_cfg_if.sv
// Capacity register write channel of the shift insert list.
// Depends on shl_pkg for the register width.
interface shl_cfg_if import shl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// File: hdl/shl_cell.sv
// One slot of the list: holds an entry and takes its neighbor's word on a shift.
// Depends on shl_pkg for the command word and widths.
module shl_cell import shl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IDX_W-1:0]       idx,
  input  cell_cmd_t              cmd,
  input  logic [ENTRY_WIDTH-1:0] lower_q,
  input  logic [ENTRY_WIDTH-1:0] upper_q,
  output logic [ENTRY_WIDTH-1:0] slot_q
);

  logic [ENTRY_WIDTH-1:0] slot_r;
  logic [ENTRY_WIDTH-1:0] slot_nxt;
  logic [CNT_W-1:0]       idx_ext;
  logic [CNT_W-1:0]       idx_inc;

  assign idx_ext = CNT_W'(idx);
  assign idx_inc = idx_ext + CNT_W'(1);

  always_comb begin
    slot_nxt = slot_r;
    case (cmd.op)
      OP_INSERT: begin
        // load at the insert point, shift up everything above it
        if (idx_ext == cmd.pos) begin
          slot_nxt = cmd.word;
        end else if (idx_ext > cmd.pos && idx_ext <= cmd.held) begin
          slot_nxt = lower_q;
        end
      end
      OP_REMOVE: begin
        // clear the vacated top slot, shift down at and above the removal point
        if (idx_inc == cmd.held) begin
          slot_nxt = '0;
        end else if (idx_ext >= cmd.pos && idx_inc < cmd.held) begin
          slot_nxt = upper_q;
        end
      end
      OP_CLEAR: slot_nxt = '0;
      default:  slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule

// File: hdl/shift_insert_list.sv
// Shift insert list: an ordered list of up to DEPTH entries held in a row of
// slot cells, with request, result and capacity-write channels.
// Depends on shl_pkg, shl_in_if, shl_out_if, shl_cfg_if and shl_cell.
//
// The list sits in a chain of DEPTH slot cells; slot 0 is the front. At the
// accepting edge of a request the top level checks it against the fill count
// and the capacity register, broadcasts one command to every cell, and every
// cell loads, shifts from a neighbor, clears or holds at once, so inserts and
// removals at any position cost the same. The answer (status, fill count after
// the request, entry read) lands in an output register at that same edge and
// shows in the cycle after. A new request is taken every cycle as long as the
// result word ahead of it is taken or the output register is empty, so the
// sustained rate is one request per cycle. Rejected requests leave the list
// untouched. Reset clears every slot and the fill count and sets the capacity
// to 16; the capacity register is limited to DEPTH when compared and may be
// written at any time the block is idle (cfg_ch.ready is always high).
module shift_insert_list import shl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  shl_in_if.sink    in_ch,
  shl_out_if.source out_ch,
  shl_cfg_if.sink   cfg_ch
);

  // Control state
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] held_nxt;
  logic             out_valid_r;

  // Result register (payload, no reset)
  status_t           status_r;
  logic [FILL_W-1:0] fill_r;
  logic [DATA_W-1:0] entry_r;

  // Request decode
  logic                   accept;
  req_t                   req;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       held_ext;
  logic [CMP_W-1:0]       limit;
  logic                   full;
  logic                   empty;
  status_t                status;
  logic                   do_read;
  logic [ENTRY_WIDTH-1:0] read_word;
  cell_cmd_t              cmd;

  logic [ENTRY_WIDTH-1:0] slot_q [DEPTH];

  // Take a new word whenever the result register is free or being drained
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign req      = req_t'(in_ch.req_type);
  assign pos_ext  = CMP_W'(in_ch.position);
  assign held_ext = CMP_W'(held_r);
  // saturate capacity at the built depth
  assign limit    = (CMP_W'(capacity_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                         : CMP_W'(capacity_r);
  assign full     = held_ext >= limit;
  assign empty    = held_r == '0;

  assign read_word = slot_q[IDX_W'(pos_ext)];

  always_comb begin
    status   = ST_DONE;
    do_read  = 1'b0;
    held_nxt = held_r;
    cmd.op   = OP_HOLD;
    cmd.pos  = '0;
    cmd.held = held_r;
    cmd.word = ENTRY_WIDTH'(in_ch.entry_in);
    case (req)
      REQ_ADD_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.op   = OP_INSERT;
          cmd.pos  = '0;
          held_nxt = held_r + CNT_W'(1);
        end
      end
      REQ_ADD_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_ext > held_ext) begin
          status = ST_RANGE;
        end else begin
          cmd.op   = OP_INSERT;
          cmd.pos  = CNT_W'(pos_ext);
          held_nxt = held_r + CNT_W'(1);
        end
      end
      REQ_ADD_END: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.op   = OP_INSERT;
          cmd.pos  = held_r;
          held_nxt = held_r + CNT_W'(1);
        end
      end
      REQ_REM_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= held_ext) begin
          status = ST_RANGE;
        end else begin
          cmd.op   = OP_REMOVE;
          cmd.pos  = CNT_W'(pos_ext);
          held_nxt = held_r - CNT_W'(1);
        end
      end
      REQ_REM_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.op   = OP_REMOVE;
          cmd.pos  = held_r - CNT_W'(1);
          held_nxt = held_r - CNT_W'(1);
        end
      end
      REQ_READ_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= held_ext) begin
          status = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      REQ_CLEAR: begin
        cmd.op   = OP_CLEAR;
        held_nxt = '0;
      end
      default: begin
        // undefined code: answer done, change nothing
        status = ST_DONE;
      end
    endcase
    // hold every cell unless a word is actually taken
    if (!accept) begin
      cmd.op   = OP_HOLD;
      held_nxt = held_r;
    end
  end

  // Slot chain: each cell sees its two neighbors, the ends see zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] lower_q;
    logic [ENTRY_WIDTH-1:0] upper_q;

    if (i == 0) begin : g_first
      assign lower_q = '0;
    end else begin : g_lower
      assign lower_q = slot_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_q = '0;
    end else begin : g_upper
      assign upper_q = slot_q[i+1];
    end

    shl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_W'(i)),
      .cmd     (cmd),
      .lower_q (lower_q),
      .upper_q (upper_q),
      .slot_q  (slot_q[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        capacity_r <= cfg_ch.capacity;
      end
      held_r <= held_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      fill_r   <= FILL_W'(held_nxt);
      entry_r  <= do_read ? DATA_W'(read_word) : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_r;
  assign out_ch.entry_out  = entry_r;

endmodule

// File: bench/shift_insert_list_tb.sv
// Self-checking bench for shift_insert_list: drives requests and capacity
// writes, predicts every result word and compares it field by field.
// Depends on shl_pkg, shl_in_if, shl_out_if, shl_cfg_if and the RTL top level.
module shift_insert_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shl_pkg::*;

  // Request code that the block must ignore: status done, list untouched.
  localparam logic [REQ_W-1:0] REQ_UNDEF = 3'd7;

  // Cap on printed mismatches; every one is still counted.
  localparam int MAX_REPORTS = 25;
  // Cycles with no word moving on any channel before the run is called hung.
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    status_t           status;
    logic [FILL_W-1:0] fill;
    logic [DATA_W-1:0] entry;
  } list_answer_t;

  // Tracks the list contents, fill count and capacity as the block should hold
  // them, and keeps the answers still owed by the block in request order.
  class shl_list_tracker;
    logic [ENTRY_WIDTH-1:0] slot_word [DEPTH];
    int unsigned            held;
    int unsigned            capacity;
    list_answer_t           owed_answers [$];
    int unsigned            failures;
    int unsigned            requests;
    int unsigned            peak_fill;
    int unsigned            status_seen [4];

    function new();
      foreach (slot_word[i]) slot_word[i] = '0;
      held     = 0;
      capacity = 16;
    endfunction

    function void insert_word(int unsigned at, logic [ENTRY_WIDTH-1:0] word);
      for (int i = held; i > at; i--) slot_word[i] = slot_word[i-1];
      slot_word[at] = word;
      held++;
    endfunction

    function void remove_word(int unsigned at);
      for (int i = at; i + 1 < held; i++) slot_word[i] = slot_word[i+1];
      slot_word[held-1] = '0;
      held--;
    endfunction

    // Apply one request to the tracked list and return the answer it earns.
    function list_answer_t apply_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                         logic [DATA_W-1:0] word);
      list_answer_t ans;
      int unsigned  limit;
      bit           full;
      limit      = (capacity > DEPTH) ? DEPTH : capacity;
      full       = (held >= limit);
      ans.status = ST_DONE;
      ans.entry  = '0;
      case (req)
        REQ_ADD_FRONT: begin
          if (full) ans.status = ST_FULL;
          else insert_word(0, word[ENTRY_WIDTH-1:0]);
        end
        REQ_ADD_POS: begin
          if (full) ans.status = ST_FULL;
          else if (pos > held) ans.status = ST_RANGE;
          else insert_word(pos, word[ENTRY_WIDTH-1:0]);
        end
        REQ_ADD_END: begin
          if (full) ans.status = ST_FULL;
          else insert_word(held, word[ENTRY_WIDTH-1:0]);
        end
        REQ_REM_POS: begin
          if (held == 0) ans.status = ST_EMPTY;
          else if (pos >= held) ans.status = ST_RANGE;
          else remove_word(pos);
        end
        REQ_REM_END: begin
          if (held == 0) ans.status = ST_EMPTY;
          else remove_word(held - 1);
        end
        REQ_READ_POS: begin
          if (held == 0) ans.status = ST_EMPTY;
          else if (pos >= held) ans.status = ST_RANGE;
          else ans.entry = DATA_W'(slot_word[pos]);
        end
        REQ_CLEAR: begin
          foreach (slot_word[i]) slot_word[i] = '0;
          held = 0;
        end
        default: ;
      endcase
      ans.fill = FILL_W'(held);
      return ans;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] word);
      list_answer_t ans;
      ans = apply_request(req, pos, word);
      owed_answers.push_back(ans);
      requests++;
      status_seen[ans.status]++;
      if (held > peak_fill) peak_fill = held;
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= MAX_REPORTS)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_answer(logic [STATUS_W-1:0] status, logic [FILL_W-1:0] fill,
                               logic [DATA_W-1:0] entry);
      list_answer_t want;
      if (owed_answers.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("result word with no request waiting: status %0d fill %0d entry 0x%0h",
                 status, fill, entry);
        return;
      end
      want = owed_answers.pop_front();
      if (status !== want.status) mismatch("status", 64'(want.status), 64'(status));
      if (fill !== want.fill) mismatch("fill_count", 64'(want.fill), 64'(fill));
      if (entry !== want.entry) mismatch("entry_out", 64'(want.entry), 64'(entry));
    endfunction

    function void close_out();
      if (owed_answers.size() != 0) begin
        failures += owed_answers.size();
        $error("%0d expected result words never arrived", owed_answers.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  shl_in_if  in_ch ();
  shl_out_if out_ch ();
  shl_cfg_if cfg_ch ();

  shift_insert_list u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  shl_list_tracker tracker = new();

  // Idle percentages for the sender and the receiver, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned caps_written  = 0;
  int          quiet_cycles  = 0;

  always #5 clk = ~clk;

  // Receiver: drop ready at random according to the current idle percentage.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: every result word taken at an edge is checked against the
  // oldest answer still owed. Values are read before the edge's updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.check_answer(out_ch.status, out_ch.fill_count, out_ch.entry_out);
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one request word. Idle first at random (valid low for whole cycles),
  // then hold valid until the block takes the word and record it.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.position <= pos;
    in_ch.entry_in <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_request(req, pos, word);
  endtask

  // Hold off the sender until every owed answer has come back; the block
  // answers in the cycle after taking a request, so a short margin is enough.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.owed_answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Capacity writes only go in while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid     <= 1'b0;
    tracker.capacity  = value;
    caps_written++;
  endtask

  // One random request. add_pct steers the mix toward growing or shrinking
  // the list so that both the full and the empty corners are reached; most
  // positions land inside the list, the rest anywhere in the field.
  task automatic send_random(input int unsigned add_pct);
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
    int unsigned       pick;
    int unsigned       top;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      req = REQ_UNDEF;
    end else if (pick < 5) begin
      req = REQ_CLEAR;
    end else if (pick < 5 + add_pct * 95 / 100) begin
      case ($urandom_range(0, 2))
        0: req = REQ_ADD_FRONT;
        1: req = REQ_ADD_POS;
        default: req = REQ_ADD_END;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: req = REQ_REM_POS;
        1: req = REQ_REM_END;
        default: req = REQ_READ_POS;
      endcase
    end
    top = (tracker.held > 15) ? 15 : tracker.held;
    if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, top));
    else pos = POS_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: word = '0;
      1: word = '1;
      default: word = {$urandom, $urandom};
    endcase
    send_word(req, pos, word);
  endtask

  // Random phase table: capacity, add weight and length of each block.
  // Capacities cover the extremes, saturation above DEPTH and drops below
  // the current fill count.
  int unsigned block_cap [7] = '{16, 16, 31, 4, 1, 0, 9};
  int unsigned block_add [7] = '{70, 35, 75, 50, 50, 40, 55};
  int unsigned block_len [7] = '{150, 110, 130, 80, 60, 40, 80};
  int unsigned mode_send [3] = '{26, 85, 0};
  int unsigned mode_recv [3] = '{85, 26, 0};

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_ADD_FRONT;
    in_ch.position  <= '0;
    in_ch.entry_in  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.capacity <= CAP_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list rejects, add at position beyond the fill count,
    // appending by position, inserts and removals in the middle, range
    // rejects, the ignored request code, full rejects (checked before the
    // position), capacity lowered below the fill count, zero capacity, clear.
    send_word(REQ_READ_POS, 4'd0, '0);
    send_word(REQ_REM_END, 4'd0, '0);
    send_word(REQ_REM_POS, 4'd3, '0);
    send_word(REQ_ADD_POS, 4'd1, 64'h1111_2222_3333_4444);
    send_word(REQ_ADD_POS, 4'd0, '1);
    send_word(REQ_ADD_FRONT, 4'd9, '0);
    send_word(REQ_ADD_END, 4'd15, 64'h8000_0000_0000_0001);
    send_word(REQ_ADD_POS, 4'd3, 64'hA5A5_A5A5_A5A5_A5A5);
    send_word(REQ_ADD_POS, 4'd1, 64'h5A5A_5A5A_5A5A_5A5A);
    send_word(REQ_READ_POS, 4'd15, '0);
    send_word(REQ_READ_POS, 4'd4, '1);
    send_word(REQ_READ_POS, 4'd0, '0);
    send_word(REQ_REM_POS, 4'd5, '0);
    send_word(REQ_REM_POS, 4'd1, '0);
    send_word(REQ_REM_END, 4'd0, '0);
    send_word(REQ_UNDEF, 4'd15, '1);
    write_capacity(CAP_W'(1));
    send_word(REQ_ADD_FRONT, 4'd0, 64'hDEAD_BEEF_0000_FFFF);
    send_word(REQ_ADD_POS, 4'd15, 64'h0123_4567_89AB_CDEF);
    send_word(REQ_READ_POS, 4'd2, '0);
    send_word(REQ_REM_POS, 4'd0, '0);
    write_capacity(CAP_W'(0));
    send_word(REQ_ADD_END, 4'd0, '1);
    send_word(REQ_CLEAR, 4'd7, '1);
    send_word(REQ_READ_POS, 4'd0, '0);

    // Random: three idle patterns, each through the whole capacity table.
    // Halfway through every block, pause the sender until no answer is owed.
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = mode_send[m];
      recv_idle_pct = mode_recv[m];
      for (int b = 0; b < 7; b++) begin
        write_capacity(CAP_W'(block_cap[b]));
        for (int n = 0; n < block_len[b]; n++) begin
          if (n == block_len[b] / 2) wait_drained();
          send_random(block_add[b]);
        end
      end
    end

    // Drain, then give any stray result word time to show up.
    wait_drained();
    repeat (4) @(posedge clk);
    tracker.close_out();

    $display("Covered %0d requests across %0d capacity writes and three idle patterns",
             tracker.requests, caps_written);
    $display("Answers done/full/range/empty: %0d/%0d/%0d/%0d, peak fill %0d",
             tracker.status_seen[ST_DONE], tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_RANGE], tracker.status_seen[ST_EMPTY],
             tracker.peak_fill);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
